FILE: src/plmv_pkg.sv
`default_nettype none
package plmv_pkg;

	localparam int MAX_LABELS = 16;
	localparam int LBL_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
	localparam int COUNT_BITS = 24;
	localparam int SMP_W = 16;
	localparam int LAB_W = 6;
	localparam int LCNT_W = 7;
	localparam logic [LCNT_W-1:0] LCNT_RESET = 7'd16;
	localparam int SUM_W = 40;
	localparam int SQ_W = 56;
	localparam int DIV_NUM_W = 56;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
	localparam int MEAN_W = 24;
	localparam int VAR_W = 30;
	localparam int CNT_OUT_W = 24;
	localparam int QMAG_W = 17;
	localparam int Q_W = 18;
	localparam int QQ_W = 32;
	localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic acc;
		logic load_entry;
		logic div_start;
		logic div_var;
		logic post_mdiv;
		logic make_qr;
		logic mul1;
		logic mul2;
		logic sub;
		logic post_vdiv;
		logic mul3;
		logic fin;
		logic out_load;
		logic idx_clr;
		logic idx_inc;
		logic clear_store;
	} plmv_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic frame_end;
		logic n_zero;
		logic n_lt2;
		logic idx_last;
		logic div_done;
		logic div_busy;
		logic out_free;
	} plmv_sts_t;

endpackage
`default_nettype wire

FILE: src/plmv_sample_if.sv
`default_nettype none
interface plmv_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic [5:0]         class_label;
	logic               counted;
	logic               frame_end;

	modport source(output valid, sample, class_label, counted, frame_end, input ready);
	modport sink(input valid, sample, class_label, counted, frame_end, output ready);
endinterface
`default_nettype wire

FILE: src/plmv_result_if.sv
`default_nettype none
interface plmv_result_if;
	logic               valid;
	logic               ready;
	logic [5:0]         out_label;
	logic signed [23:0] mean_value;
	logic [29:0]        variance_value;
	logic               variance_infinite;
	logic [23:0]        sample_count;
	logic               last_label;

	modport source(output valid, out_label, mean_value, variance_value, variance_infinite,
		sample_count, last_label, input ready);
	modport sink(input valid, out_label, mean_value, variance_value, variance_infinite,
		sample_count, last_label, output ready);
endinterface
`default_nettype wire

FILE: src/plmv_cfg_if.sv
`default_nettype none
interface plmv_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] label_count;

	modport source(output valid, label_count, input ready);
	modport sink(input valid, label_count, output ready);
endinterface
`default_nettype wire

FILE: src/per_label_mean_variance.sv
`default_nettype none
// per-label mean and variance: each request carries a signed sample, a label, a mask bit and an
// end-of-frame mark. a counted request whose label is below label_count (0 acts as 1, values
// above 16 act as 16) adds the sample to that label's sum, sum of squares and count, until the
// count saturates. a request is captured, then the label store does one read-modify-write for
// it. the end-of-frame request is accumulated first, then one result per label is sent in
// label order and the store is cleared. per label the shared bit-serial divider runs once for
// the mean when the count is not zero and once more for the variance when the count is at
// least two; a result that is not taken holds the readout. no request is taken during
// readout; the label_count register is always ready and should only be written while the
// block is idle.
module per_label_mean_variance (
	input  wire logic       clk,
	input  wire logic       arst_n,
	plmv_sample_if.sink     samples,
	plmv_result_if.source   results,
	plmv_cfg_if.sink        cfg
);
	import plmv_pkg::*;

	plmv_cmd_t cmd;
	plmv_sts_t sts;
	logic      in_ready;

	// register port never stalls
	assign cfg.ready = 1'b1;
	assign samples.ready = in_ready;

	plmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	plmv_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.sample            (samples.sample),
		.class_label       (samples.class_label),
		.counted           (samples.counted),
		.frame_end         (samples.frame_end),
		.cfg_valid         (cfg.valid),
		.cfg_data          (cfg.label_count),
		.res_valid         (results.valid),
		.res_ready         (results.ready),
		.out_label         (results.out_label),
		.mean_value        (results.mean_value),
		.variance_value    (results.variance_value),
		.variance_infinite (results.variance_infinite),
		.sample_count      (results.sample_count),
		.last_label        (results.last_label)
	);

	// divider is never restarted while running
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	// a result is only loaded into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");

	// an accepted request is always followed by its store update
	a_acc_next: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> (cmd.acc && !samples.ready))
		else $error("accepted request not accumulated");
endmodule
`default_nettype wire

FILE: src/plmv_div.sv
`default_nettype none
module plmv_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [plmv_pkg::DIV_NUM_W-1:0]    num,
	input  wire logic [plmv_pkg::COUNT_BITS-1:0]   den,
	output logic                                   busy,
	output logic                                   done,
	output logic [plmv_pkg::DIV_NUM_W-1:0]         quo,
	output logic [plmv_pkg::COUNT_BITS-1:0]        rem
);
	import plmv_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [DIV_NUM_W-1:0]   quo_q;
	logic [COUNT_BITS-1:0]  rem_q;
	logic [COUNT_BITS:0]    trial;
	logic                   ge;
	logic [COUNT_BITS:0]    diff;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge = trial >= {1'b0, den};
	assign diff = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = quo_q;
	assign rem = rem_q;
endmodule
`default_nettype wire

FILE: src/plmv_datapath.sv
`default_nettype none
module plmv_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire plmv_pkg::plmv_cmd_t        cmd,
	output plmv_pkg::plmv_sts_t             sts,
	input  wire logic signed [15:0]         sample,
	input  wire logic [5:0]                 class_label,
	input  wire logic                       counted,
	input  wire logic                       frame_end,
	input  wire logic                       cfg_valid,
	input  wire logic [6:0]                 cfg_data,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output logic [5:0]                      out_label,
	output logic signed [23:0]              mean_value,
	output logic [29:0]                     variance_value,
	output logic                            variance_infinite,
	output logic [23:0]                     sample_count,
	output logic                            last_label
);
	import plmv_pkg::*;

	// label store, valid bits stand for the cleared state
	logic signed [SUM_W-1:0]  sum_mem [MAX_LABELS];
	logic [SQ_W-1:0]          sq_mem [MAX_LABELS];
	logic [COUNT_BITS-1:0]    tally_mem [MAX_LABELS];
	logic [MAX_LABELS-1:0]    vld_q;

	logic [LCNT_W-1:0]        lcnt_q;
	logic [LCNT_W-1:0]        eff;
	logic signed [SMP_W-1:0]  smp_q;
	logic [LAB_W-1:0]         lab_q;
	logic                     cnt_q;
	logic                     fe_q;
	logic [LBL_W-1:0]         idx_q;

	logic [LBL_W-1:0]         rd_addr;
	logic signed [SUM_W-1:0]  sum_rd;
	logic [SQ_W-1:0]          sq_rd;
	logic [COUNT_BITS-1:0]    tally_rd;
	logic                     hit;
	logic signed [31:0]       sqr;

	logic                     neg_q;
	logic [SUM_W-1:0]         mag_q;
	logic [SQ_W-1:0]          sq_w_q;
	logic [COUNT_BITS-1:0]    n_q;
	logic [MEAN_W-1:0]        mean_q;
	logic [VAR_W-1:0]         var_q;
	logic [QMAG_W-1:0]        qmag_q;
	logic [COUNT_BITS-1:0]    rraw_q;
	logic signed [Q_W-1:0]    q_q;
	logic [COUNT_BITS-1:0]    r_q;
	logic [QQ_W-1:0]          qq_q;
	logic signed [Q_W+COUNT_BITS:0] qr_q;
	logic [COUNT_BITS+QQ_W-1:0] nqq_q;
	logic [DIV_NUM_W-1:0]     t_q;
	logic [DIV_NUM_W-1:0]     a_q;
	logic [COUNT_BITS-1:0]    b_q;
	logic [2*COUNT_BITS-1:0]  bn_q;
	logic [2*COUNT_BITS-1:0]  rr_q;

	logic [DIV_NUM_W-1:0]     div_num;
	logic [DIV_NUM_W-1:0]     div_quo;
	logic [COUNT_BITS-1:0]    div_rem;
	logic                     div_busy;
	logic                     div_done;

	logic [COUNT_BITS+7:0]    kn;
	logic [COUNT_BITS+8:0]    rsum;
	logic [MEAN_W-1:0]        q256;
	logic [Q_W-1:0]           qpos;
	logic signed [2*Q_W-1:0]  qq_full;
	logic signed [Q_W+COUNT_BITS:0] qr_full;
	logic [COUNT_BITS+QQ_W-1:0] nqq_full;
	logic signed [SQ_W+1:0]   t_full;
	logic                     idx_last;

	assign eff = (lcnt_q == '0) ? LCNT_W'(1) :
		(lcnt_q > LCNT_W'(MAX_LABELS)) ? LCNT_W'(MAX_LABELS) : lcnt_q;

	assign rd_addr = cmd.acc ? lab_q[LBL_W-1:0] : idx_q;
	assign sum_rd = vld_q[rd_addr] ? sum_mem[rd_addr] : '0;
	assign sq_rd = vld_q[rd_addr] ? sq_mem[rd_addr] : '0;
	assign tally_rd = vld_q[rd_addr] ? tally_mem[rd_addr] : '0;
	assign hit = cnt_q && (LCNT_W'(lab_q) < eff) && (tally_rd != TALLY_MAX);
	assign sqr = smp_q * smp_q;
	assign idx_last = (LCNT_W'(idx_q) + LCNT_W'(1)) == eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q <= LCNT_RESET;
		end else if (cfg_valid) begin
			lcnt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			smp_q <= sample;
			lab_q <= class_label;
			cnt_q <= counted;
			fe_q <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.clear_store)
				vld_q <= '0;
			else if (cmd.acc && hit)
				vld_q[rd_addr] <= 1'b1;
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc && hit) begin
			sum_mem[rd_addr] <= sum_rd + SUM_W'(smp_q);
			sq_mem[rd_addr] <= sq_rd + SQ_W'($unsigned(sqr));
			tally_mem[rd_addr] <= tally_rd + 1'b1;
		end
	end

	plmv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (n_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign div_num = cmd.div_var ? t_q : DIV_NUM_W'({mag_q, 8'b0});

	// remainder of |sum| / n from the scaled quotient and remainder
	assign kn = div_quo[7:0] * n_q;
	assign rsum = (COUNT_BITS+9)'(kn) + (COUNT_BITS+9)'(div_rem);
	assign q256 = div_quo[MEAN_W-1:0];
	assign qpos = Q_W'(qmag_q);
	assign qq_full = q_q * q_q;
	assign qr_full = q_q * $signed({1'b0, r_q});
	assign nqq_full = n_q * qq_q;
	assign t_full = $signed((SQ_W+2)'(sq_w_q)) - $signed((SQ_W+2)'(nqq_q))
		- ((SQ_W+2)'(qr_q) <<< 1);

	always_ff @(posedge clk) begin
		if (cmd.load_entry) begin
			neg_q <= sum_rd[SUM_W-1];
			mag_q <= sum_rd[SUM_W-1] ? $unsigned(-sum_rd) : $unsigned(sum_rd);
			sq_w_q <= sq_rd;
			n_q <= tally_rd;
			mean_q <= '0;
			var_q <= '0;
		end
		if (cmd.post_mdiv) begin
			mean_q <= neg_q ? -q256 : q256;
			qmag_q <= div_quo[QMAG_W+7:8];
			rraw_q <= rsum[COUNT_BITS+7:8];
		end
		if (cmd.make_qr) begin
			// floored quotient and nonnegative remainder
			if (neg_q && rraw_q != '0) begin
				q_q <= $signed(~qpos);
				r_q <= n_q - rraw_q;
			end else if (neg_q) begin
				q_q <= $signed(-qpos);
				r_q <= '0;
			end else begin
				q_q <= $signed(qpos);
				r_q <= rraw_q;
			end
		end
		if (cmd.mul1) begin
			qq_q <= qq_full[QQ_W-1:0];
			qr_q <= qr_full;
		end
		if (cmd.mul2)
			nqq_q <= nqq_full;
		if (cmd.sub)
			t_q <= t_full[DIV_NUM_W-1:0];
		if (cmd.post_vdiv) begin
			a_q <= div_quo;
			b_q <= div_rem;
		end
		if (cmd.mul3) begin
			bn_q <= b_q * n_q;
			rr_q <= r_q * r_q;
		end
		if (cmd.fin)
			var_q <= (bn_q < rr_q && a_q != '0) ? VAR_W'(a_q - 1'b1) : VAR_W'(a_q);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_label <= 6'(idx_q);
			mean_value <= $signed(mean_q);
			variance_value <= var_q;
			variance_infinite <= n_q < COUNT_BITS'(2);
			sample_count <= CNT_OUT_W'(n_q);
			last_label <= idx_last;
		end
	end

	assign sts.frame_end = fe_q;
	assign sts.n_zero = n_q == '0;
	assign sts.n_lt2 = n_q < COUNT_BITS'(2);
	assign sts.idx_last = idx_last;
	assign sts.div_done = div_done;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !res_valid || res_ready;
endmodule
`default_nettype wire

FILE: src/plmv_ctrl.sv
`default_nettype none
module plmv_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire plmv_pkg::plmv_sts_t  sts,
	output plmv_pkg::plmv_cmd_t       cmd
);
	import plmv_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACC, ST_LOAD, ST_MDIV, ST_MWAIT, ST_QR, ST_MUL1, ST_MUL2,
		ST_SUB, ST_VDIV, ST_VWAIT, ST_MUL3, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (sts.frame_end) begin
					cmd.idx_clr = 1'b1;
					state_d = ST_LOAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LOAD: begin
				cmd.load_entry = 1'b1;
				state_d = ST_MDIV;
			end
			ST_MDIV: begin
				if (sts.n_zero) begin
					state_d = ST_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_MWAIT;
				end
			end
			ST_MWAIT: begin
				if (sts.div_done) begin
					cmd.post_mdiv = 1'b1;
					state_d = sts.n_lt2 ? ST_OUT : ST_QR;
				end
			end
			ST_QR: begin
				cmd.make_qr = 1'b1;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = ST_VDIV;
			end
			ST_VDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_var = 1'b1;
				state_d = ST_VWAIT;
			end
			ST_VWAIT: begin
				cmd.div_var = 1'b1;
				if (sts.div_done) begin
					cmd.post_vdiv = 1'b1;
					state_d = ST_MUL3;
				end
			end
			ST_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.idx_last) begin
						cmd.clear_store = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
	logic [5:0]         out_label;
	logic signed [23:0] mean_value;
	logic [29:0]        variance_value;
	logic               variance_infinite;
	logic [23:0]        sample_count;
	logic               last_label;
} label_stat_t;

// tracks the per-label sums and the statistics expected at each frame end
class label_stats_board;
	longint signed   label_sum [plmv_pkg::MAX_LABELS];
	longint unsigned label_sq [plmv_pkg::MAX_LABELS];
	longint unsigned label_cnt [plmv_pkg::MAX_LABELS];
	logic [6:0]      label_count;
	label_stat_t     expected_stats[$];
	int              mismatches;

	function void clear_store();
		for (int i = 0; i < plmv_pkg::MAX_LABELS; i++) begin
			label_sum[i] = 0;
			label_sq[i] = 0;
			label_cnt[i] = 0;
		end
	endfunction

	function void reset_state();
		clear_store();
		label_count = plmv_pkg::LCNT_RESET;
		expected_stats.delete();
		mismatches = 0;
	endfunction

	function int active_labels();
		if (label_count == 0)
			return 1;
		if (label_count > plmv_pkg::MAX_LABELS)
			return plmv_pkg::MAX_LABELS;
		return label_count;
	endfunction

	function void note_request(logic signed [15:0] smp, logic [5:0] lab, logic cnt, logic fe);
		int eff;
		longint signed x;
		logic signed [127:0] num;
		logic signed [127:0] den;
		label_stat_t r;
		eff = active_labels();
		x = smp;
		if (cnt && lab < eff && label_cnt[lab] < (64'd1 << plmv_pkg::COUNT_BITS) - 1) begin
			label_sum[lab] += x;
			label_sq[lab] += x * x;
			label_cnt[lab] += 1;
		end
		if (!fe)
			return;
		for (int i = 0; i < eff; i++) begin
			r.out_label = 6'(i);
			r.mean_value = 0;
			r.variance_value = 0;
			if (label_cnt[i] > 0)
				r.mean_value = 24'((label_sum[i] * 256) / longint'(label_cnt[i]));
			if (label_cnt[i] > 1) begin
				num = $signed({64'd0, label_sq[i]}) * $signed({64'd0, label_cnt[i]})
					- $signed(128'(label_sum[i])) * $signed(128'(label_sum[i]));
				den = $signed({64'd0, label_cnt[i]}) * $signed({64'd0, label_cnt[i]});
				r.variance_value = 30'(num / den);
			end
			r.variance_infinite = label_cnt[i] < 2;
			r.sample_count = 24'(label_cnt[i]);
			r.last_label = (i + 1 == eff);
			expected_stats.push_back(r);
		end
		clear_store();
	endfunction

	function void check_result(label_stat_t got);
		label_stat_t exp_r;
		if (expected_stats.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result label %0d", got.out_label);
			return;
		end
		exp_r = expected_stats.pop_front();
		if (got != exp_r) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch exp lab=%0d mean=%0d var=%0d inf=%0d cnt=%0d last=%0d | got lab=%0d mean=%0d var=%0d inf=%0d cnt=%0d last=%0d",
					exp_r.out_label, exp_r.mean_value, exp_r.variance_value,
					exp_r.variance_infinite, exp_r.sample_count, exp_r.last_label,
					got.out_label, got.mean_value, got.variance_value,
					got.variance_infinite, got.sample_count, got.last_label);
		end
	endfunction
endclass

module tb;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	int   cycles = 0;
	bit   no_idle;

	label_stats_board board;

	plmv_sample_if smp_if();
	plmv_result_if res_if();
	plmv_cfg_if    cfg_if();

	per_label_mean_variance dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(smp_if.sink),
		.results(res_if.source),
		.cfg(cfg_if.sink)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// send one request, with a random gap ahead of it unless idling is off
	task automatic send_request(logic signed [15:0] smp, logic [5:0] lab, logic cnt, logic fe);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			smp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.sample <= smp;
		smp_if.class_label <= lab;
		smp_if.counted <= cnt;
		smp_if.frame_end <= fe;
		do @(posedge clk); while (!smp_if.ready);
		board.note_request(smp, lab, cnt, fe);
	endtask

	// write label_count; only called while the block is idle
	task automatic write_label_count(logic [6:0] value);
		smp_if.valid <= 1'b0;
		cfg_if.valid <= 1'b1;
		cfg_if.label_count <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		board.label_count = value;
	endtask

	// let the readout drain, plus a margin for a request still in flight
	task automatic wait_drained();
		smp_if.valid <= 1'b0;
		while (board.expected_stats.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// random frame: mostly in-range counted labels, some noise labels and masked samples
	task automatic random_frame(int len);
		int eff;
		logic [5:0] lab;
		eff = board.active_labels();
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				lab = 6'($urandom_range(0, 63));
			else
				lab = 6'($urandom_range(0, eff - 1));
			send_request(pick_sample(), lab, $urandom_range(0, 7) != 0, i == len - 1);
		end
	endtask

	// result side: random stalls, check each accepted result
	initial begin
		int stall;
		label_stat_t got;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			got.out_label = res_if.out_label;
			got.mean_value = res_if.mean_value;
			got.variance_value = res_if.variance_value;
			got.variance_infinite = res_if.variance_infinite;
			got.sample_count = res_if.sample_count;
			got.last_label = res_if.last_label;
			board.check_result(got);
		end
	end

	initial begin
		logic [6:0] phase_counts[8];
		board = new;
		board.reset_state();
		no_idle = 0;
		arst_n = 1'b0;
		smp_if.valid = 1'b0;
		smp_if.sample = '0;
		smp_if.class_label = '0;
		smp_if.counted = 1'b0;
		smp_if.frame_end = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.label_count = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, masked and out-of-range labels, counts of zero and one
		send_request(16'sh7fff, 6'd0, 1'b1, 1'b0);
		send_request(16'sh8000, 6'd0, 1'b1, 1'b0);
		send_request(16'sh7fff, 6'd0, 1'b1, 1'b0);
		send_request(16'sh0100, 6'd1, 1'b1, 1'b0);        // label 1 sees one sample
		send_request(16'sh1234, 6'd2, 1'b0, 1'b0);        // masked out
		send_request(16'sh0042, 6'd16, 1'b1, 1'b0);       // label not in use
		send_request(16'sh0042, 6'd63, 1'b1, 1'b0);
		send_request(16'shffff, 6'd3, 1'b1, 1'b0);
		send_request(16'sh8000, 6'd3, 1'b1, 1'b0);
		send_request(16'sh8000, 6'd3, 1'b1, 1'b0);
		send_request(-16'sd3, 6'd4, 1'b1, 1'b0);
		send_request(16'sd2, 6'd4, 1'b1, 1'b0);
		send_request(16'sd2, 6'd4, 1'b1, 1'b0);
		send_request(16'sh5555, 6'd15, 1'b1, 1'b0);
		send_request(16'shaaaa, 6'd15, 1'b1, 1'b0);
		send_request(16'sh0009, 6'd5, 1'b0, 1'b1);        // frame end on a masked sample
		send_request(-16'sd300, 6'd5, 1'b1, 1'b1);        // frame end that is itself counted
		wait_drained();

		// label_count out of range on both sides, then the extremes in use
		write_label_count(7'd0);
		send_request(16'sh0080, 6'd0, 1'b1, 1'b0);
		send_request(16'sh0080, 6'd1, 1'b1, 1'b1);
		wait_drained();
		write_label_count(7'd127);
		send_request(16'sh7fff, 6'd15, 1'b1, 1'b0);
		send_request(16'sh8000, 6'd15, 1'b1, 1'b1);
		wait_drained();

		// random phases across several settings
		phase_counts = '{7'd1, 7'd64, 7'd16, 7'd5, 7'd17, 7'd2, 7'd9, 7'd16};
		foreach (phase_counts[p]) begin
			write_label_count(phase_counts[p]);
			no_idle = (p == 2 || p == 6);
			for (int f = 0; f < 3; f++)
				random_frame($urandom_range(1, 14));
			wait_drained();
		end
		no_idle = 0;
		write_label_count(7'($urandom_range(1, 64)));
		repeat (4) random_frame($urandom_range(1, 12));
		wait_drained();

		repeat (300) @(posedge clk);
		if (board.mismatches == 0 && board.expected_stats.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
